>>> src/lna_pkg.sv
// ----------------------------------------------------------------------------
// lna_pkg
// Shared types, sizes and codes of the landmark nearest-association block.
// ----------------------------------------------------------------------------
`default_nettype none

package lna_pkg;

  // Table geometry.
  localparam int LANDMARK_DEPTH = 64;
  localparam int IDX_W          = $clog2(LANDMARK_DEPTH);
  localparam int USED_W         = $clog2(LANDMARK_DEPTH + 1);

  // Sighting count saturates the blend weight at COUNT_CAP; stored value reaches COUNT_CAP+1.
  localparam int COUNT_CAP = 5;
  localparam int CNT_W     = $clog2(COUNT_CAP + 2);

  // Field widths.
  localparam int POS_W      = 16;
  localparam int GATE_W     = 15;
  localparam int LM_IDX_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int DIST_W     = POS_W + 2;
  // Blend numerator c*old + obs and its magnitude.
  localparam int SUM_W      = POS_W + CNT_W + 1;
  localparam int MAG_W      = SUM_W - 1;

  // Gate reset values (0.05 m and 0.15 m in Q3.12).
  localparam logic [GATE_W-1:0] ASSOC_GATE_RST = GATE_W'(205);
  localparam logic [GATE_W-1:0] NEW_GATE_RST   = GATE_W'(614);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_GATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_GATE   = CFG_IDX_W'(1);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ASSOC   = 2'd0,
    ST_NEW     = 2'd1,
    ST_OUTLIER = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // One landmark table entry.
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [CNT_W-1:0]        cnt;
  } entry_t;

  // Write request into the landmark table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  // Read request into the landmark table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

endpackage

`default_nettype wire

>>> src/lna_table_ram.sv
// ----------------------------------------------------------------------------
// lna_table_ram
// Landmark table: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lna_table_ram
  import lna_pkg::*;
(
  input  wire logic    clk_i,
  input  wire tbl_wr_t wr_i,
  input  wire tbl_rd_t rd_i,
  output entry_t       rdata_o
);

  entry_t mem [LANDMARK_DEPTH];
  entry_t rdata_q;

  // Synchronous write and read; the read data appears in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/lna_blend_div.sv
// ----------------------------------------------------------------------------
// lna_blend_div
// Signed divide of the blend numerator by a small count, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lna_blend_div
  import lna_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0]        divisor_i,
  output logic                         done_o,
  output logic signed [POS_W-1:0]      quotient_o
);

  localparam int STEP_W = $clog2(MAG_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [MAG_W-1:0]  work_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dsr_q;
  logic              neg_q;

  logic [SUM_W-1:0]  mag_full;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_diff;
  logic              trial_ge;
  logic [MAG_W-1:0]  q_signed;

  // Magnitude of the dividend; the sign is restored at the end.
  assign mag_full = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial      = {rem_q, work_q[MAG_W-1]};
  assign trial_diff = trial - {1'b0, dsr_q};
  assign trial_ge   = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == STEP_W'(MAG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  // Datapath: the quotient bits shift into the low end of the work register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= mag_full[MAG_W-1:0];
      rem_q  <= '0;
      dsr_q  <= divisor_i;
      neg_q  <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      work_q <= {work_q[MAG_W-2:0], trial_ge};
      rem_q  <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // Truncation toward zero: negate the magnitude quotient when needed.
  assign q_signed   = neg_q ? (~work_q + MAG_W'(1)) : work_q;
  assign quotient_o = q_signed[POS_W-1:0];
  assign done_o     = done_q;

endmodule

`default_nettype wire

>>> src/landmark_nearest_association.sv
// ----------------------------------------------------------------------------
// landmark_nearest_association
// Nearest-landmark association by Manhattan distance with merge and append.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_stall_o    obs_x_i, obs_y_i, frame_start_i
//   out      source     out_valid_o / out_stall_i  landmark_index_o, status_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One observation is handled at a time. A search issues one table read per
// stored entry, compares each entry once its read data returns and then
// closes; a merge adds a pass through the bit-serial dividers. A dropped item
// then goes straight to its result, an appended one first writes the table,
// and a bulk append skips the search. A finished result moves into the
// output register; while a previous result is still stalled there, the
// new one waits and the input stays stalled.
// Reset clears the control state and the entry count; table contents stay
// undefined and are never read before written. Configuration is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module landmark_nearest_association
  import lna_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Observation channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic signed [POS_W-1:0] obs_x_i,
  input  wire logic signed [POS_W-1:0] obs_y_i,
  input  wire logic                    frame_start_i,
  // Result channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [LM_IDX_W-1:0]          landmark_index_o,
  output logic [1:0]                   status_o,
  // Configuration channel
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [GATE_W-1:0]       cfg_data_i
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  function automatic logic [POS_W:0] abs_diff(input logic signed [POS_W-1:0] a,
                                              input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    return d[POS_W] ? (~d + (POS_W+1)'(1)) : d;
  endfunction

  logic [2:0]              state_q, state_d;
  logic [GATE_W-1:0]       assoc_gate_q, new_gate_q;
  logic signed [POS_W-1:0] obs_x_q, obs_y_q;
  logic                    bulk_q, bulk_d;
  logic [USED_W-1:0]       used_q;
  logic [USED_W-1:0]       scan_cnt_q;
  logic                    cmp_vld_q;
  logic [IDX_W-1:0]        cmp_idx_q;
  logic                    best_vld_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic [DIST_W-1:0]       best_d_q;
  entry_t                  best_q;
  logic [IDX_W-1:0]        res_idx_q;
  status_e                 res_status_q;
  logic                    out_valid_q;
  logic [LM_IDX_W-1:0]     out_idx_q;
  logic [1:0]              out_status_q;

  logic                    in_fire;
  logic                    issue;
  logic                    out_free;
  logic                    scan_done;
  logic                    table_full;
  entry_t                  rdata;
  logic [DIST_W-1:0]       cur_d;
  logic                    take;
  logic                    merge;
  logic                    far;
  logic [CNT_W-1:0]        c_lim;
  logic [CNT_W-1:0]        c_inc;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic                    div_start;
  logic                    div_x_done, div_y_done;
  logic                    div_done;
  logic signed [POS_W-1:0] qx, qy;
  tbl_wr_t                 tbl_wr;
  tbl_rd_t                 tbl_rd;

  assign in_fire    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !(out_valid_q && out_stall_i);
  assign cfg_ready_o = 1'b1;

  // Bulk-frame flag as seen by the item now entering.
  assign bulk_d = frame_start_i ? (used_q == '0) : bulk_q;

  // Search pipeline: issue one read a cycle, compare the entry in the cycle after its read.
  assign issue     = (state_q == S_SCAN) && (scan_cnt_q < used_q);
  assign scan_done = (state_q == S_SCAN) && !issue && !cmp_vld_q;
  assign cur_d     = DIST_W'(abs_diff(rdata.x, obs_x_q)) + DIST_W'(abs_diff(rdata.y, obs_y_q));
  // Ties go to the later entry.
  assign take      = !best_vld_q || (cur_d <= best_d_q);

  // Gate tests on the nearest distance.
  assign merge = (best_d_q < DIST_W'(assoc_gate_q));
  assign far   = (best_d_q > DIST_W'(new_gate_q));

  // Blend numerators c*old + obs with c capped at COUNT_CAP.
  assign c_lim = (best_q.cnt > CNT_W'(COUNT_CAP)) ? CNT_W'(COUNT_CAP) : best_q.cnt;
  assign c_inc = c_lim + CNT_W'(1);
  assign sum_x = SUM_W'($signed({1'b0, c_lim})) * SUM_W'($signed(best_q.x)) + SUM_W'(obs_x_q);
  assign sum_y = SUM_W'($signed({1'b0, c_lim})) * SUM_W'($signed(best_q.y)) + SUM_W'(obs_y_q);
  assign div_start = (state_q == S_DECIDE) && merge;

  // Both dividers run in lockstep, so the pair is done when both flags are up.
  assign div_done = div_x_done && div_y_done;

  assign table_full = (used_q == USED_W'(LANDMARK_DEPTH));

  // Table port requests. Items are handled one at a time, so a write-back
  // always lands before the next search reads the table.
  always_comb begin
    tbl_rd.en   = issue;
    tbl_rd.addr = scan_cnt_q[IDX_W-1:0];
    tbl_wr      = '0;
    if ((state_q == S_APPEND) && !table_full) begin
      tbl_wr.en        = 1'b1;
      tbl_wr.addr      = used_q[IDX_W-1:0];
      tbl_wr.data.x    = obs_x_q;
      tbl_wr.data.y    = obs_y_q;
      tbl_wr.data.cnt  = CNT_W'(1);
    end else if ((state_q == S_DIV) && div_done) begin
      tbl_wr.en        = 1'b1;
      tbl_wr.addr      = best_idx_q;
      tbl_wr.data.x    = qx;
      tbl_wr.data.y    = qy;
      tbl_wr.data.cnt  = c_inc;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (bulk_d || (used_q == '0)) ? S_APPEND : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (merge) begin
          state_d = S_DIV;
        end else if (far) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_RESULT;
        end
      end
      S_APPEND: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      assoc_gate_q <= ASSOC_GATE_RST;
      new_gate_q   <= NEW_GATE_RST;
      bulk_q       <= 1'b0;
      used_q       <= '0;
      cmp_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= issue;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ASSOC_GATE: assoc_gate_q <= cfg_data_i;
          CFG_NEW_GATE:   new_gate_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        bulk_q <= bulk_d;
      end
      if ((state_q == S_APPEND) && !table_full) begin
        used_q <= used_q + USED_W'(1);
      end
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search datapath and result staging.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      obs_x_q    <= obs_x_i;
      obs_y_q    <= obs_y_i;
      scan_cnt_q <= '0;
      best_vld_q <= 1'b0;
    end
    if (issue) begin
      scan_cnt_q <= scan_cnt_q + USED_W'(1);
    end
    cmp_idx_q <= scan_cnt_q[IDX_W-1:0];
    // Keep the nearest entry's contents so a merge needs no second read.
    if (cmp_vld_q && take) begin
      best_vld_q <= 1'b1;
      best_idx_q <= cmp_idx_q;
      best_d_q   <= cur_d;
      best_q     <= rdata;
    end
    case (state_q)
      S_DECIDE: begin
        res_idx_q    <= '0;
        res_status_q <= ST_OUTLIER;
      end
      S_APPEND: begin
        res_idx_q    <= table_full ? '0 : used_q[IDX_W-1:0];
        res_status_q <= table_full ? ST_FULL : ST_NEW;
      end
      S_DIV: begin
        res_idx_q    <= best_idx_q;
        res_status_q <= ST_ASSOC;
      end
      default: ;
    endcase
    if ((state_q == S_RESULT) && out_free) begin
      out_idx_q    <= LM_IDX_W'(res_idx_q);
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign landmark_index_o = out_idx_q;
  assign status_o         = out_status_q;

  lna_table_ram u_table (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .rd_i    (tbl_rd),
    .rdata_o (rdata)
  );

  lna_blend_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_x),
    .divisor_i  (c_inc),
    .done_o     (div_x_done),
    .quotient_o (qx)
  );

  // Runs in lockstep with the x divider; its done flag mirrors that one.
  lna_blend_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_y),
    .divisor_i  (c_inc),
    .done_o     (div_y_done),
    .quotient_o (qy)
  );

endmodule

`default_nettype wire

>>> src/lna_checker.sv
// ----------------------------------------------------------------------------
// lna_props
// Port-level checks of the landmark nearest-association block.
// ----------------------------------------------------------------------------
`default_nettype none

module lna_props
  import lna_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic signed [POS_W-1:0] obs_x_i,
  input wire logic signed [POS_W-1:0] obs_y_i,
  input wire logic                    frame_start_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [LM_IDX_W-1:0]     landmark_index_o,
  input wire logic [1:0]              status_o,
  input wire logic                    cfg_valid_i,
  input wire logic                    cfg_ready_o,
  input wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input wire logic [GATE_W-1:0]       cfg_data_i
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(landmark_index_o) && $stable(status_o))
    else $error("stalled result changed");

  // Once an observation is taken the block is busy until its result is staged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second observation taken while busy");

  // A result never appears in the cycle right after its observation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Dropped and full results carry index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OUTLIER || status_o == ST_FULL) |-> landmark_index_o == '0)
    else $error("nonzero index on dropped result");

endmodule

bind landmark_nearest_association lna_props u_lna_props (.*);

`default_nettype wire
